FILE: design/mbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbd_pkg;

  localparam int unsigned NUM_BUTTONS = 5;
  localparam int unsigned STATE_W     = 2;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned DEB_W       = 16;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned APB_AW      = 3;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [STATE_W-1:0] btn_state_t;
  typedef logic [TIME_W-1:0]  tick_t;
  typedef logic [DEB_W-1:0]   deb_time_t;

  localparam op_t OP_UPDATE   = 2'd0;
  localparam op_t OP_SIM_PRESS = 2'd1;
  localparam op_t OP_SIM_REL  = 2'd2;
  localparam op_t OP_INIT     = 2'd3;

  localparam btn_state_t ST_RELEASED = 2'd0;
  localparam btn_state_t ST_PRESSED  = 2'd1;
  localparam btn_state_t ST_HELD     = 2'd2;

  localparam logic [APB_AW-1:0] ADDR_DEBOUNCE = 3'd0;
  localparam deb_time_t         DEBOUNCE_RST  = 16'd50;

  typedef struct packed {
    op_t                    op;
    logic [NUM_BUTTONS-1:0] raw_pressed;
    logic [IDX_W-1:0]       button_index;
    tick_t                  now;
  } in_word_t;

  typedef struct packed {
    logic [STATE_W*NUM_BUTTONS-1:0] button_states;
    logic [NUM_BUTTONS-1:0]         pressed_mask;
  } out_word_t;

endpackage

`default_nettype wire

FILE: design/mbd_button.sv
`timescale 1ns / 1ps
`default_nettype none

module mbd_button (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     en_i,
  input  wire mbd_pkg::op_t       op_i,
  input  wire                     sel_i,
  input  wire                     level_i,
  input  wire mbd_pkg::tick_t     now_i,
  input  wire mbd_pkg::deb_time_t debounce_time_i,
  output mbd_pkg::btn_state_t     state_d_o
);
  import mbd_pkg::*;

  btn_state_t st_q, st_d;
  tick_t      press_q, press_d, rel_q, rel_d;
  logic       last_q, last_d, forced_q, forced_d;
  tick_t      press_age, rel_age, deb_ext;
  logic       press_ok, rel_ok;

  assign deb_ext   = TIME_W'(debounce_time_i);
  assign press_age = now_i - press_q;
  assign rel_age   = now_i - rel_q;
  assign press_ok  = (press_age >= deb_ext);
  assign rel_ok    = (rel_age >= deb_ext);

  always_comb begin
    st_d     = st_q;
    press_d  = press_q;
    rel_d    = rel_q;
    last_d   = last_q;
    forced_d = forced_q;
    if (en_i) begin
      unique case (op_i)
        OP_UPDATE: begin
          if (forced_q) begin
            last_d = (st_q == ST_PRESSED) || (st_q == ST_HELD);
          end else begin
            if (level_i != last_q) begin
              if (level_i) press_d = now_i;
              else         rel_d   = now_i;
            end else if (level_i) begin
              if (press_ok) st_d = (st_q == ST_RELEASED) ? ST_PRESSED : ST_HELD;
            end else begin
              if (rel_ok) st_d = ST_RELEASED;
            end
            last_d = level_i;
          end
        end
        OP_SIM_PRESS: begin
          if (sel_i) begin
            forced_d = 1'b1;
            press_d  = now_i - deb_ext;
            st_d     = ST_PRESSED;
            last_d   = 1'b1;
          end
        end
        OP_SIM_REL: begin
          if (sel_i) begin
            forced_d = 1'b1;
            rel_d    = now_i;
            st_d     = ST_RELEASED;
            last_d   = 1'b0;
          end
        end
        OP_INIT: begin
          st_d     = ST_RELEASED;
          last_d   = level_i;
          press_d  = now_i;
          rel_d    = now_i;
          forced_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_RELEASED;
      press_q  <= '0;
      rel_q    <= '0;
      last_q   <= 1'b0;
      forced_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      press_q  <= press_d;
      rel_q    <= rel_d;
      last_q   <= last_d;
      forced_q <= forced_d;
    end
  end

  assign state_d_o = st_d;

endmodule

`default_nettype wire

FILE: design/multi_button_debouncer_top.sv
// An accepted input word's result word is on the output register in the next cycle.
// Throughput: one word per cycle unless stalled; each button's update is a parallel
// 32-bit subtract and compare done in the accept cycle, so words enter back to back while
// the output drains. Reset (rst_ni, async, active low): all buttons released, not
// simulated, stamps zero, debounce_time 50, output empty.
`timescale 1ns / 1ps
`default_nettype none

module multi_button_debouncer_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire mbd_pkg::in_word_t           in_word_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output mbd_pkg::out_word_t               out_word_o,
  input  wire                              psel_i,
  input  wire                              penable_i,
  input  wire                              pwrite_i,
  input  wire  [mbd_pkg::APB_AW-1:0]       paddr_i,
  input  wire  [mbd_pkg::APB_DW-1:0]       pwdata_i,
  output logic [mbd_pkg::APB_DW-1:0]       prdata_o,
  output logic                             pready_o
);
  import mbd_pkg::*;

  deb_time_t  deb_q;
  logic       cfg_wr;
  logic       in_acc;
  logic       out_valid_q, out_valid_d;
  out_word_t  out_q, out_d;
  btn_state_t st_next [NUM_BUTTONS];

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i == ADDR_DEBOUNCE);
  assign prdata_o = (paddr_i == ADDR_DEBOUNCE) ? APB_DW'(deb_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= DEBOUNCE_RST;
    end else if (cfg_wr) begin
      deb_q <= pwdata_i[DEB_W-1:0];
    end
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    mbd_button u_btn (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .en_i            (in_acc),
      .op_i            (in_word_i.op),
      .sel_i           (in_word_i.button_index == IDX_W'(i)),
      .level_i         (in_word_i.raw_pressed[i]),
      .now_i           (in_word_i.now),
      .debounce_time_i (deb_q),
      .state_d_o       (st_next[i])
    );
  end

  always_comb begin
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (in_acc) begin
      out_valid_d = 1'b1;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        out_d.button_states[STATE_W*i +: STATE_W] = st_next[i];
        out_d.pressed_mask[i] = (st_next[i] == ST_PRESSED) || (st_next[i] == ST_HELD);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire
